// File: hdl/phs_pkg.sv
// ----------------------------------------------------------------------------
// phs_pkg
// shared types, sizes and codes of the proton hop state search
// ----------------------------------------------------------------------------
`default_nettype none

package phs_pkg;

    localparam int MAX_ATOMS   = 256;
    localparam int STATE_SLOTS = 16;
    localparam int ATOM_W      = $clog2(MAX_ATOMS);
    localparam int SLOT_W      = $clog2(STATE_SLOTS);
    localparam int TBL_AW      = ATOM_W + SLOT_W;
    localparam int TBL_DEPTH   = MAX_ATOMS * STATE_SLOTS;
    localparam int CNT_W       = ATOM_W + 1;
    localparam int NST_W       = SLOT_W + 1;
    localparam int COORD_W     = 24;
    localparam int SQ_W        = 2 * (COORD_W + 1);
    localparam int ACC_W       = SQ_W;

    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_RUN  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;

    localparam logic [1:0] EL_HYDROGEN = 2'd1;
    localparam logic [1:0] EL_OXYGEN   = 2'd2;

    localparam logic [1:0] CFG_ATOM_COUNT   = 2'd0;
    localparam logic [1:0] CFG_REACTIVE_FRAG = 2'd1;
    localparam logic [1:0] CFG_CUTOFF       = 2'd2;
    localparam logic [1:0] CFG_HOP_LIMIT    = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } coord_t;

    typedef struct packed {
        logic [1:0] elem;
        coord_t     pos;
    } atom_word_t;

    typedef struct packed {
        logic [TBL_AW-1:0] rd_a_addr;
        logic [TBL_AW-1:0] rd_b_addr;
        logic [TBL_AW-1:0] wr_addr;
        logic              frag_we;
        logic [7:0]        frag_wd;
        logic              react_we;
        logic              react_wd;
        logic [ATOM_W-1:0] env_rd_addr;
        logic              env_we;
        logic [ATOM_W-1:0] env_wr_addr;
        logic              env_wd;
        logic [ATOM_W-1:0] atom_rd_addr;
        logic              atom_we;
        logic [ATOM_W-1:0] atom_wr_addr;
        atom_word_t        atom_wd;
    } tbl_ctrl_t;

    typedef struct packed {
        logic [7:0] frag_a;
        logic       react_a;
        logic [7:0] frag_b;
        logic       env;
        atom_word_t atom;
    } tbl_data_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_INIT_RD,
        ST_INIT_WR,
        ST_LOOP,
        ST_I_RD,
        ST_I_CHK,
        ST_J_RD,
        ST_J_CHK,
        ST_DIST,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_DONATE,
        ST_NEXT,
        ST_ENV_RD,
        ST_ENV_CHK,
        ST_FINISH
    } fsm_t;

endpackage

`default_nettype wire

// File: hdl/proton_hop_state_search.sv
// ----------------------------------------------------------------------------
// proton_hop_state_search
// breadth-first search of proton hop states over a loaded set of atoms
// ----------------------------------------------------------------------------
// Requests arrive on the s_ channel (valid/ready), one result per request
// leaves on the m_ channel. Load writes one atom (element, coordinates and
// pivot fragment); read returns one atom's fragment and reactive bit for a
// state row plus its environment bit; run does the search.
// A run walks all hydrogen and oxygen pairs of every state through one
// shared squared-distance unit, copies a full table row per new state, and
// closes with an environment pass over every atom and state; its length
// therefore grows with atoms squared times states.
// One request is worked on at a time; s_ready is low while a result waits.
// The status fields (state count, final hop, change flags) come with every
// result and hold the values of the last run.
// After reset the tables are cleared, one entry per cycle, with s_ready
// low; configuration writes are taken at any time.
// A stalled receiver simply holds the result until m_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module proton_hop_state_search
    import phs_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_wr_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [15:0]        cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_opcode,
    input  wire logic [7:0]         s_atom_index,
    input  wire logic [1:0]         s_element,
    input  wire logic [7:0]         s_pivot_fragment,
    input  wire logic signed [23:0] s_pos_x,
    input  wire logic signed [23:0] s_pos_y,
    input  wire logic signed [23:0] s_pos_z,
    input  wire logic [3:0]         s_state_select,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_atom_fragment,
    output logic                    m_atom_reactive,
    output logic                    m_atom_environment,
    output logic [4:0]              m_state_count,
    output logic [3:0]              m_final_hop,
    output logic                    m_indexing_changed,
    output logic                    m_count_changed,
    output logic                    m_reuse_allowed
);

    fsm_t              fsm_reg, fsm_next;
    logic [TBL_AW-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [NST_W-1:0]  nst_reg, nst_next;
    logic [NST_W-1:0]  st_reg, st_next;
    logic [3:0]        hop_reg, hop_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [SLOT_W-1:0] s_reg, s_next;
    logic              found_reg, found_next;
    logic [7:0]        accf_reg, accf_next;
    logic              idxch_reg, idxch_next;
    logic [31:0]       cut2_reg, cut2_next;
    coord_t            ci_reg, ci_next;
    logic [3:0]        hops_reg [STATE_SLOTS];
    logic [3:0]        hops_next [STATE_SLOTS];
    logic [MAX_ATOMS-1:0] avail_reg, avail_next;
    logic [MAX_ATOMS-1:0] pend_reg, pend_next;

    logic [8:0]  atom_count_reg;
    logic [7:0]  react_frag_reg;
    logic [15:0] cutoff_reg;
    logic [3:0]  hop_limit_reg;

    logic [4:0] last_cnt_reg, last_cnt_next;
    logic [3:0] fhop_reg, fhop_next;
    logic       idxf_reg, idxf_next;
    logic       cntf_reg, cntf_next;
    logic       reuse_reg, reuse_next;
    logic [7:0] ofrag_reg, ofrag_next;
    logic       oreact_reg, oreact_next;
    logic       oenv_reg, oenv_next;
    logic       mvalid_reg, mvalid_next;

    tbl_ctrl_t ctrl;
    tbl_data_t data;
    logic      dist_start;
    logic      dist_done;
    logic      dist_near;

    phs_tables u_tables (
        .aclk (aclk),
        .ctrl (ctrl),
        .data (data)
    );

    phs_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (dist_start),
        .pos_a   (ci_reg),
        .pos_b   (data.atom.pos),
        .cut2    (cut2_reg),
        .done    (dist_done),
        .near    (dist_near)
    );

    assign s_ready = (fsm_reg == ST_IDLE) && !mvalid_reg;

    always_comb begin
        logic [NST_W-1:0] st_inc;
        logic             own;
        logic [7:0]       nf;
        logic             fr;
        logic             hit;

        fsm_next      = fsm_reg;
        clr_next      = clr_reg;
        n_next        = n_reg;
        nst_next      = nst_reg;
        st_next       = st_reg;
        hop_next      = hop_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        s_next        = s_reg;
        found_next    = found_reg;
        accf_next     = accf_reg;
        idxch_next    = idxch_reg;
        cut2_next     = cut2_reg;
        ci_next       = ci_reg;
        hops_next     = hops_reg;
        avail_next    = avail_reg;
        pend_next     = pend_reg;
        last_cnt_next = last_cnt_reg;
        fhop_next     = fhop_reg;
        idxf_next     = idxf_reg;
        cntf_next     = cntf_reg;
        reuse_next    = reuse_reg;
        ofrag_next    = ofrag_reg;
        oreact_next   = oreact_reg;
        oenv_next     = oenv_reg;
        mvalid_next   = mvalid_reg && !m_ready;
        dist_start    = 1'b0;

        ctrl              = '0;
        ctrl.rd_a_addr    = {st_reg[SLOT_W-1:0], i_reg[ATOM_W-1:0]};
        ctrl.rd_b_addr    = {nst_reg[SLOT_W-1:0], k_reg[ATOM_W-1:0]};
        ctrl.wr_addr      = {nst_reg[SLOT_W-1:0], k_reg[ATOM_W-1:0]};
        ctrl.env_rd_addr  = s_atom_index;
        ctrl.env_wr_addr  = i_reg[ATOM_W-1:0];
        ctrl.atom_rd_addr = i_reg[ATOM_W-1:0];
        ctrl.atom_wr_addr = s_atom_index;
        ctrl.atom_wd      = '{elem: s_element, pos: '{z: s_pos_z, y: s_pos_y, x: s_pos_x}};

        st_inc = st_reg + NST_W'(1);
        own    = (k_reg == i_reg);
        nf     = own ? accf_reg : data.frag_a;
        fr     = found_reg || data.react_a;
        hit    = (data.frag_a == react_frag_reg);

        unique case (fsm_reg)
            ST_CLEAR: begin
                ctrl.wr_addr     = clr_reg;
                ctrl.frag_we     = 1'b1;
                ctrl.react_we    = 1'b1;
                ctrl.env_we      = 1'b1;
                ctrl.env_wr_addr = clr_reg[ATOM_W-1:0];
                clr_next         = clr_reg + TBL_AW'(1);
                if (clr_reg == TBL_AW'(TBL_DEPTH - 1)) begin
                    fsm_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                ctrl.rd_a_addr = {s_state_select, s_atom_index};
                if (s_valid && s_ready) begin
                    unique case (s_opcode)
                        OP_LOAD: begin
                            ctrl.atom_we  = 1'b1;
                            ctrl.frag_we  = 1'b1;
                            ctrl.wr_addr  = {SLOT_W'(0), s_atom_index};
                            ctrl.frag_wd  = s_pivot_fragment;
                            ofrag_next    = '0;
                            oreact_next   = 1'b0;
                            oenv_next     = 1'b0;
                            mvalid_next   = 1'b1;
                        end
                        OP_RUN: begin
                            pend_next    = '0;
                            hops_next[0] = '0;
                            nst_next     = NST_W'(1);
                            st_next      = '0;
                            hop_next     = '0;
                            idxch_next   = 1'b0;
                            k_next       = '0;
                            cut2_next    = 32'(cutoff_reg) * 32'(cutoff_reg);
                            n_next       = (atom_count_reg > CNT_W'(MAX_ATOMS)) ?
                                           CNT_W'(MAX_ATOMS) : CNT_W'(atom_count_reg);
                            fsm_next     = (atom_count_reg == '0) ? ST_LOOP : ST_INIT_RD;
                        end
                        OP_READ: begin
                            fsm_next = ST_READ;
                        end
                        default: begin
                            ofrag_next  = '0;
                            oreact_next = 1'b0;
                            oenv_next   = 1'b0;
                            mvalid_next = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ: begin
                ofrag_next  = data.frag_a;
                oreact_next = data.react_a;
                oenv_next   = data.env;
                mvalid_next = 1'b1;
                fsm_next    = ST_IDLE;
            end
            ST_INIT_RD: begin
                ctrl.rd_a_addr    = {SLOT_W'(0), k_reg[ATOM_W-1:0]};
                ctrl.atom_rd_addr = k_reg[ATOM_W-1:0];
                fsm_next          = ST_INIT_WR;
            end
            ST_INIT_WR: begin
                ctrl.wr_addr  = {SLOT_W'(0), k_reg[ATOM_W-1:0]};
                ctrl.react_we = 1'b1;
                ctrl.react_wd = hit;
                // an oxygen whose fragment is the reactive fragment never accepts
                avail_next[k_reg[ATOM_W-1:0]] = !(hit && data.atom.elem == EL_OXYGEN);
                k_next = k_reg + CNT_W'(1);
                fsm_next = (CNT_W'(k_reg + CNT_W'(1)) == n_reg) ? ST_LOOP : ST_INIT_RD;
            end
            ST_LOOP: begin
                i_next     = '0;
                s_next     = '0;
                found_next = 1'b0;
                if (st_reg < nst_reg && !st_reg[SLOT_W] && hop_reg < hop_limit_reg) begin
                    fsm_next = ST_I_RD;
                end else begin
                    fsm_next = ST_ENV_RD;
                end
            end
            ST_I_RD: begin
                if (i_reg == n_reg) begin
                    fsm_next = ST_NEXT;
                end else begin
                    fsm_next = ST_I_CHK;
                end
            end
            ST_I_CHK: begin
                ci_next = data.atom.pos;
                if (data.atom.elem == EL_HYDROGEN && avail_reg[i_reg[ATOM_W-1:0]]
                    && data.react_a) begin
                    j_next   = '0;
                    fsm_next = ST_J_RD;
                end else begin
                    i_next   = i_reg + CNT_W'(1);
                    fsm_next = ST_I_RD;
                end
            end
            ST_J_RD: begin
                ctrl.rd_a_addr    = {st_reg[SLOT_W-1:0], j_reg[ATOM_W-1:0]};
                ctrl.atom_rd_addr = j_reg[ATOM_W-1:0];
                if (j_reg == n_reg) begin
                    avail_next[i_reg[ATOM_W-1:0]] = 1'b0;
                    i_next   = i_reg + CNT_W'(1);
                    fsm_next = ST_I_RD;
                end else begin
                    fsm_next = ST_J_CHK;
                end
            end
            ST_J_CHK: begin
                accf_next = data.frag_a;
                // a full table skips the donation without tagging the oxygen
                if (data.atom.elem == EL_OXYGEN && avail_reg[j_reg[ATOM_W-1:0]]
                    && !data.react_a && !nst_reg[SLOT_W]) begin
                    dist_start = 1'b1;
                    fsm_next   = ST_DIST;
                end else begin
                    j_next   = j_reg + CNT_W'(1);
                    fsm_next = ST_J_RD;
                end
            end
            ST_DIST: begin
                if (dist_done) begin
                    if (dist_near) begin
                        k_next   = '0;
                        fsm_next = ST_COPY_RD;
                    end else begin
                        j_next   = j_reg + CNT_W'(1);
                        fsm_next = ST_J_RD;
                    end
                end
            end
            ST_COPY_RD: begin
                ctrl.rd_a_addr = {st_reg[SLOT_W-1:0], k_reg[ATOM_W-1:0]};
                fsm_next       = ST_COPY_WR;
            end
            ST_COPY_WR: begin
                ctrl.frag_we  = 1'b1;
                ctrl.frag_wd  = nf;
                ctrl.react_we = 1'b1;
                ctrl.react_wd = own || (data.frag_a == accf_reg);
                if (data.frag_b != nf) begin
                    idxch_next = 1'b1;
                end
                k_next   = k_reg + CNT_W'(1);
                fsm_next = (CNT_W'(k_reg + CNT_W'(1)) == n_reg) ? ST_DONATE : ST_COPY_RD;
            end
            ST_DONATE: begin
                hops_next[nst_reg[SLOT_W-1:0]] = hops_reg[st_reg[SLOT_W-1:0]] + 4'd1;
                pend_next[j_reg[ATOM_W-1:0]]   = 1'b1;
                nst_next = nst_reg + NST_W'(1);
                j_next   = j_reg + CNT_W'(1);
                fsm_next = ST_J_RD;
            end
            ST_NEXT: begin
                st_next = st_inc;
                if (st_inc < nst_reg) begin
                    hop_next   = hops_reg[st_inc[SLOT_W-1:0]];
                    avail_next = avail_reg & ~pend_reg;
                    pend_next  = '0;
                end
                fsm_next = ST_LOOP;
            end
            ST_ENV_RD: begin
                ctrl.rd_a_addr = {s_reg, i_reg[ATOM_W-1:0]};
                if (i_reg == CNT_W'(MAX_ATOMS)) begin
                    fsm_next = ST_FINISH;
                end else if (i_reg >= n_reg) begin
                    ctrl.env_we = 1'b1;
                    ctrl.env_wd = 1'b0;
                    i_next      = i_reg + CNT_W'(1);
                end else begin
                    fsm_next = ST_ENV_CHK;
                end
            end
            ST_ENV_CHK: begin
                if (NST_W'(s_reg) + NST_W'(1) == nst_reg) begin
                    ctrl.env_we = 1'b1;
                    ctrl.env_wd = !fr;
                    found_next  = 1'b0;
                    s_next      = '0;
                    i_next      = i_reg + CNT_W'(1);
                end else begin
                    found_next = fr;
                    s_next     = s_reg + SLOT_W'(1);
                end
                fsm_next = ST_ENV_RD;
            end
            ST_FINISH: begin
                last_cnt_next = 5'(nst_reg);
                fhop_next     = hop_reg;
                idxf_next     = idxch_reg;
                cntf_next     = (last_cnt_reg != 5'(nst_reg));
                reuse_next    = (last_cnt_reg == 5'(nst_reg)) && !idxch_reg;
                ofrag_next    = '0;
                oreact_next   = 1'b0;
                oenv_next     = 1'b0;
                mvalid_next   = 1'b1;
                fsm_next      = ST_IDLE;
            end
            default: begin
                fsm_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fsm_reg        <= ST_CLEAR;
            clr_reg        <= '0;
            mvalid_reg     <= 1'b0;
            last_cnt_reg   <= '0;
            fhop_reg       <= '0;
            idxf_reg       <= 1'b0;
            cntf_reg       <= 1'b0;
            reuse_reg      <= 1'b0;
            atom_count_reg <= 9'd1;
            react_frag_reg <= 8'd0;
            cutoff_reg     <= 16'd9830;
            hop_limit_reg  <= 4'd2;
        end else begin
            fsm_reg      <= fsm_next;
            clr_reg      <= clr_next;
            mvalid_reg   <= mvalid_next;
            last_cnt_reg <= last_cnt_next;
            fhop_reg     <= fhop_next;
            idxf_reg     <= idxf_next;
            cntf_reg     <= cntf_next;
            reuse_reg    <= reuse_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    CFG_ATOM_COUNT:    atom_count_reg <= cfg_wdata[8:0];
                    CFG_REACTIVE_FRAG: react_frag_reg <= cfg_wdata[7:0];
                    CFG_CUTOFF:        cutoff_reg     <= cfg_wdata;
                    CFG_HOP_LIMIT:     hop_limit_reg  <= cfg_wdata[3:0];
                    default: ;
                endcase
            end
        end
        n_reg      <= n_next;
        nst_reg    <= nst_next;
        st_reg     <= st_next;
        hop_reg    <= hop_next;
        i_reg      <= i_next;
        j_reg      <= j_next;
        k_reg      <= k_next;
        s_reg      <= s_next;
        found_reg  <= found_next;
        accf_reg   <= accf_next;
        idxch_reg  <= idxch_next;
        cut2_reg   <= cut2_next;
        ci_reg     <= ci_next;
        hops_reg   <= hops_next;
        avail_reg  <= avail_next;
        pend_reg   <= pend_next;
        ofrag_reg  <= ofrag_next;
        oreact_reg <= oreact_next;
        oenv_reg   <= oenv_next;
    end

    assign m_valid            = mvalid_reg;
    assign m_atom_fragment    = ofrag_reg;
    assign m_atom_reactive    = oreact_reg;
    assign m_atom_environment = oenv_reg;
    assign m_state_count      = last_cnt_reg;
    assign m_final_hop        = fhop_reg;
    assign m_indexing_changed = idxf_reg;
    assign m_count_changed    = cntf_reg;
    assign m_reuse_allowed    = reuse_reg;

    // a run never answers in the cycle after its request
    a_run_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_opcode == OP_RUN) |=> !m_valid)
        else $error("run result came too early");

    // state count never goes past the table size
    a_state_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (nst_reg <= NST_W'(STATE_SLOTS)) || (fsm_reg == ST_IDLE) || (fsm_reg == ST_CLEAR))
        else $error("state count beyond table");

    // no request is taken while the tables are being cleared
    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (fsm_reg == ST_CLEAR) |-> !s_ready)
        else $error("request taken during clear");

    // the state count only moves together with a new result
    a_status_with_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(last_cnt_reg) |-> m_valid)
        else $error("state count changed without a result");

endmodule

`default_nettype wire

// File: hdl/phs_tables.sv
// ----------------------------------------------------------------------------
// phs_tables
// atom store, fragment and reactive tables, environment bits
// ----------------------------------------------------------------------------
`default_nettype none

module phs_tables
    import phs_pkg::*;
(
    input  wire logic aclk,
    input  tbl_ctrl_t ctrl,
    output tbl_data_t data
);

    logic [7:0] frag_mem  [TBL_DEPTH];
    logic       react_mem [TBL_DEPTH];
    logic       env_mem   [MAX_ATOMS];
    atom_word_t atom_mem  [MAX_ATOMS];

    tbl_data_t data_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.frag_we) begin
            frag_mem[ctrl.wr_addr] <= ctrl.frag_wd;
        end
        if (ctrl.react_we) begin
            react_mem[ctrl.wr_addr] <= ctrl.react_wd;
        end
        if (ctrl.env_we) begin
            env_mem[ctrl.env_wr_addr] <= ctrl.env_wd;
        end
        if (ctrl.atom_we) begin
            atom_mem[ctrl.atom_wr_addr] <= ctrl.atom_wd;
        end
        data_reg.frag_a  <= frag_mem[ctrl.rd_a_addr];
        data_reg.react_a <= react_mem[ctrl.rd_a_addr];
        data_reg.frag_b  <= frag_mem[ctrl.rd_b_addr];
        data_reg.env     <= env_mem[ctrl.env_rd_addr];
        data_reg.atom    <= atom_mem[ctrl.atom_rd_addr];
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: hdl/phs_dist.sv
// ----------------------------------------------------------------------------
// phs_dist
// squared distance unit: one multiplier, one axis per cycle, cutoff compare
// ----------------------------------------------------------------------------
`default_nettype none

module phs_dist
    import phs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  coord_t           pos_a,
    input  coord_t           pos_b,
    input  wire logic [31:0] cut2,
    output logic             done,
    output logic             near
);

    logic             busy_reg, busy_next;
    logic [1:0]       axis_reg, axis_next;
    coord_t           a_reg, a_next, b_reg, b_next;
    logic [SQ_W-1:0]  prod_reg, prod_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             done_reg, done_next;
    logic             near_reg, near_next;

    logic signed [COORD_W:0] diff;
    logic signed [SQ_W-1:0]  sq;
    logic [ACC_W-1:0]        sum;

    always_comb begin
        unique case (axis_reg)
            2'd0:    diff = (COORD_W+1)'(a_reg.x) - (COORD_W+1)'(b_reg.x);
            2'd1:    diff = (COORD_W+1)'(a_reg.y) - (COORD_W+1)'(b_reg.y);
            default: diff = (COORD_W+1)'(a_reg.z) - (COORD_W+1)'(b_reg.z);
        endcase
        sq  = diff * diff;
        sum = acc_reg + prod_reg;
    end

    always_comb begin
        busy_next = busy_reg;
        axis_next = axis_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        prod_next = prod_reg;
        acc_next  = acc_reg;
        done_next = 1'b0;
        near_next = near_reg;
        if (start) begin
            busy_next = 1'b1;
            axis_next = 2'd0;
            a_next    = pos_a;
            b_next    = pos_b;
            acc_next  = '0;
        end else if (busy_reg) begin
            // product of one axis is added in the following cycle
            if (axis_reg != 2'd3) begin
                prod_next = SQ_W'(sq);
            end
            if (axis_reg != 2'd0) begin
                acc_next = sum;
            end
            if (axis_reg == 2'd3) begin
                busy_next = 1'b0;
                done_next = 1'b1;
                near_next = sum < ACC_W'(cut2);
            end
            axis_next = axis_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            axis_reg <= 2'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            axis_reg <= axis_next;
        end
        a_reg    <= a_next;
        b_reg    <= b_next;
        prod_reg <= prod_next;
        acc_reg  <= acc_next;
        near_reg <= near_next;
    end

    assign done = done_reg;
    assign near = near_reg;

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the proton hop state search
// ----------------------------------------------------------------------------
// A scoreboard object keeps its own copy of the atom store, the state tables
// and the registers, and works out the result of every accepted request.
// Every atom slot is loaded first, so no search touches an unwritten entry.
// A directed scene covers hops, cutoff and hop limit extremes, an empty
// search and stale rows. Random phases then load small clusters of atoms
// with random fragments, run searches and read rows back, under varied
// register settings and at most two searches over all slots. Both channels stall
// at random.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import phs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] EL_OTHER = 2'd0;
    localparam int         CYCLE_LIMIT = 3000000;
    localparam int         ITEM_GOAL = 750;

    typedef struct {
        logic [7:0] frag;
        logic       react;
        logic       env;
        logic [4:0] count;
        logic [3:0] hop;
        logic       idx_changed;
        logic       cnt_changed;
        logic       reuse;
    } hop_result_t;

    class hop_scoreboard;
        int unsigned atom_count = 1;
        logic [7:0]  react_frag = 8'd0;
        logic [15:0] cutoff = 16'd9830;
        logic [3:0]  hop_limit = 4'd2;

        logic [1:0]        elem [MAX_ATOMS];
        logic signed [23:0] pos [3*MAX_ATOMS];
        logic [7:0]  frag_tbl [TBL_DEPTH];
        bit          react_tbl [TBL_DEPTH];
        logic [3:0]  hops [STATE_SLOTS];
        bit          avail [MAX_ATOMS];
        bit          pend [MAX_ATOMS];
        bit          env_bits [MAX_ATOMS];
        logic [4:0]  last_count = 5'd0;
        logic [7:0]  flags = 8'd0;

        hop_result_t expected_q [$];
        int errors = 0;

        function new();
            for (int i = 0; i < TBL_DEPTH; i++) begin
                frag_tbl[i] = 8'd0;
            end
            for (int i = 0; i < MAX_ATOMS; i++) begin
                elem[i] = EL_OTHER;
            end
            for (int i = 0; i < 3*MAX_ATOMS; i++) begin
                pos[i] = '0;
            end
            for (int i = 0; i < STATE_SLOTS; i++) begin
                hops[i] = 4'd0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                CFG_ATOM_COUNT:    atom_count = val[8:0];
                CFG_REACTIVE_FRAG: react_frag = val[7:0];
                CFG_CUTOFF:        cutoff = val;
                CFG_HOP_LIMIT:     hop_limit = val[3:0];
                default: ;
            endcase
        endfunction

        function longint unsigned dist_sq(int unsigned a, int unsigned b);
            longint unsigned sum;
            longint d;
            sum = 0;
            for (int c = 0; c < 3; c++) begin
                d = longint'(pos[3*a+c]) - longint'(pos[3*b+c]);
                sum += longint'(d * d);
            end
            return sum;
        endfunction

        function void search();
            int unsigned n, prev, nst, st, hop, base, nb;
            longint unsigned cut2;
            bit idx_ch, cnt_ch, env;
            logic [7:0] accf;
            logic [7:0] row_old [MAX_ATOMS];
            n = (atom_count > MAX_ATOMS) ? MAX_ATOMS : atom_count;
            prev = last_count;
            nst = 1;
            st = 0;
            hop = 0;
            cut2 = longint'(cutoff) * longint'(cutoff);
            idx_ch = 0;
            for (int k = 0; k < MAX_ATOMS; k++) pend[k] = 0;
            hops[0] = 4'd0;
            for (int i = 0; i < n; i++) begin
                avail[i] = 1;
                if (frag_tbl[i] == react_frag) begin
                    react_tbl[i] = 1;
                    if (elem[i] == EL_OXYGEN) avail[i] = 0;
                end else begin
                    react_tbl[i] = 0;
                end
            end
            while (st < nst && st < STATE_SLOTS && hop < hop_limit) begin
                base = st * MAX_ATOMS;
                for (int i = 0; i < n; i++) begin
                    if (!(elem[i] == EL_HYDROGEN && avail[i] && react_tbl[base+i])) continue;
                    for (int j = 0; j < n; j++) begin
                        if (!(elem[j] == EL_OXYGEN && avail[j] && !react_tbl[base+j])) continue;
                        if (dist_sq(i, j) >= cut2) continue;
                        if (nst >= STATE_SLOTS) continue;
                        nb = nst * MAX_ATOMS;
                        accf = frag_tbl[base+j];
                        for (int k = 0; k < n; k++) begin
                            row_old[k] = frag_tbl[nb+k];
                            frag_tbl[nb+k] = frag_tbl[base+k];
                            react_tbl[nb+k] = (frag_tbl[base+k] == accf);
                        end
                        frag_tbl[nb+i] = accf;
                        react_tbl[nb+i] = 1;
                        for (int k = 0; k < n; k++)
                            if (row_old[k] != frag_tbl[nb+k]) idx_ch = 1;
                        hops[nst] = hops[st] + 4'd1;
                        pend[j] = 1;
                        nst++;
                    end
                    avail[i] = 0;
                end
                st++;
                if (st < nst) begin
                    hop = hops[st];
                    for (int k = 0; k < MAX_ATOMS; k++) begin
                        if (pend[k]) avail[k] = 0;
                        pend[k] = 0;
                    end
                end
            end
            for (int i = 0; i < MAX_ATOMS; i++) begin
                env = 0;
                if (i < n) begin
                    env = 1;
                    for (int s = 0; s < nst; s++)
                        if (react_tbl[s*MAX_ATOMS+i]) env = 0;
                end
                env_bits[i] = env;
            end
            last_count = nst[4:0];
            cnt_ch = (prev != last_count);
            flags = {1'b0, !cnt_ch && !idx_ch, cnt_ch, idx_ch, hop[3:0]};
        endfunction

        // an accepted request: update the model and queue what it returns
        function void note_request(logic [1:0] op, logic [7:0] idx, logic [1:0] el,
                                   logic [7:0] pf, logic signed [23:0] x,
                                   logic signed [23:0] y, logic signed [23:0] z,
                                   logic [3:0] sel);
            hop_result_t r;
            r.frag = 8'd0;
            r.react = 0;
            r.env = 0;
            if (op == OP_LOAD) begin
                elem[idx] = el;
                frag_tbl[idx] = pf;
                pos[3*idx] = x;
                pos[3*idx+1] = y;
                pos[3*idx+2] = z;
            end else if (op == OP_RUN) begin
                search();
            end else if (op == OP_READ) begin
                r.env = env_bits[idx];
                r.frag = frag_tbl[sel*MAX_ATOMS+idx];
                r.react = react_tbl[sel*MAX_ATOMS+idx];
            end
            r.count = last_count;
            r.hop = flags[3:0];
            r.idx_changed = flags[4];
            r.cnt_changed = flags[5];
            r.reuse = flags[6];
            expected_q.push_back(r);
        endfunction

        function void compare(string name, int e, int a);
            if (e != a) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, e, a);
            end
        endfunction

        function void check_result(hop_result_t got);
            hop_result_t e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: result with no request outstanding", $time);
                return;
            end
            e = expected_q.pop_front();
            compare("atom_fragment", e.frag, got.frag);
            compare("atom_reactive", e.react, got.react);
            compare("atom_environment", e.env, got.env);
            compare("state_count", e.count, got.count);
            compare("final_hop", e.hop, got.hop);
            compare("indexing_changed", e.idx_changed, got.idx_changed);
            compare("count_changed", e.cnt_changed, got.cnt_changed);
            compare("reuse_allowed", e.reuse, got.reuse);
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               cfg_wr_en = 0;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_wdata = '0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [1:0]         s_opcode = '0;
    logic [7:0]         s_atom_index = '0;
    logic [1:0]         s_element = '0;
    logic [7:0]         s_pivot_fragment = '0;
    logic signed [23:0] s_pos_x = '0;
    logic signed [23:0] s_pos_y = '0;
    logic signed [23:0] s_pos_z = '0;
    logic [3:0]         s_state_select = '0;
    logic               m_valid;
    logic               m_ready = 0;
    logic [7:0]         m_atom_fragment;
    logic               m_atom_reactive;
    logic               m_atom_environment;
    logic [4:0]         m_state_count;
    logic [3:0]         m_final_hop;
    logic               m_indexing_changed;
    logic               m_count_changed;
    logic               m_reuse_allowed;

    proton_hop_state_search dut (.*);

    hop_scoreboard sb = new();
    bit quiet = 0;
    int cycles = 0;
    int n_load = 0, n_run = 0, n_read = 0, n_phase = 0, n_results = 0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stalls, check every accepted result
    initial begin
        hop_result_t got;
        int gap;
        @(posedge aresetn);
        forever begin
            gap = quiet ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_ready <= 0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            got.frag = m_atom_fragment;
            got.react = m_atom_reactive;
            got.env = m_atom_environment;
            got.count = m_state_count;
            got.hop = m_final_hop;
            got.idx_changed = m_indexing_changed;
            got.cnt_changed = m_count_changed;
            got.reuse = m_reuse_allowed;
            sb.check_result(got);
            n_results++;
        end
    end

    // valid stays high across back-to-back requests, lowered only for a gap
    task automatic send(logic [1:0] op, logic [7:0] idx, logic [1:0] el, logic [7:0] pf,
                        logic signed [23:0] x, logic signed [23:0] y,
                        logic signed [23:0] z, logic [3:0] sel);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_valid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1;
        s_opcode <= op;
        s_atom_index <= idx;
        s_element <= el;
        s_pivot_fragment <= pf;
        s_pos_x <= x;
        s_pos_y <= y;
        s_pos_z <= z;
        s_state_select <= sel;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(op, idx, el, pf, x, y, z, sel);
        case (op)
            OP_LOAD: n_load++;
            OP_RUN:  n_run++;
            default: n_read++;
        endcase
    endtask

    task automatic load(logic [7:0] idx, logic [1:0] el, logic [7:0] pf,
                        logic signed [23:0] x, logic signed [23:0] y, logic signed [23:0] z);
        send(OP_LOAD, idx, el, pf, x, y, z, 4'($urandom));
    endtask

    task automatic run_search();
        send(OP_RUN, 8'($urandom), 2'($urandom_range(0, 2)), 8'($urandom),
             24'($urandom), 24'($urandom), 24'($urandom), 4'($urandom));
    endtask

    task automatic read_atom(logic [7:0] idx, logic [3:0] sel);
        send(OP_READ, idx, 2'($urandom_range(0, 2)), 8'($urandom),
             24'($urandom), 24'($urandom), 24'($urandom), sel);
    endtask

    // stop sending and let every outstanding request come back
    task automatic drain();
        s_valid <= 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic configure(int unsigned cnt, logic [7:0] rf, logic [15:0] cut,
                             logic [3:0] hl);
        logic [1:0]  idx [4];
        logic [15:0] val [4];
        idx = '{CFG_ATOM_COUNT, CFG_REACTIVE_FRAG, CFG_CUTOFF, CFG_HOP_LIMIT};
        val = '{16'(cnt), {8'd0, rf}, cut, {12'd0, hl}};
        drain();
        for (int i = 0; i < 4; i++) begin
            cfg_wr_en <= 1;
            cfg_index <= idx[i];
            cfg_wdata <= val[i];
            @(posedge aclk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_wr_en <= 0;
        @(posedge aclk);
    endtask

    function automatic logic signed [23:0] near(logic signed [23:0] c);
        return c + 24'(int'($urandom_range(0, 12000)) - 6000);
    endfunction

    initial begin
        int unsigned n;
        logic [7:0] rf;
        logic [1:0] el;
        logic signed [23:0] bx, by, bz;
        int pick, big_left;
        big_left = 2;

        repeat (10) @(posedge aclk);
        aresetn <= 1;

        // before any search: status is all zero
        read_atom(8'd0, 4'd0);

        // every slot gets defined content, full coordinate range included
        for (int i = 0; i < MAX_ATOMS; i++) begin
            load(8'(i), 2'($urandom_range(0, 2)), 8'($urandom),
                 24'($urandom), 24'($urandom), 24'($urandom));
        end
        load(8'd254, EL_OTHER, 8'hff, 24'sh7fffff, 24'sh7fffff, 24'sh7fffff);
        load(8'd255, EL_OTHER, 8'h00, -24'sh800000, -24'sh800000, -24'sh800000);

        // directed scene: donor h0 to o1/o2, second hop via h3 of fragment 5
        configure(5, 8'd7, 16'd9830, 4'd2);
        load(8'd0, EL_HYDROGEN, 8'd7, 24'sd0, 24'sd0, 24'sd0);
        load(8'd1, EL_OXYGEN, 8'd5, 24'sd4096, 24'sd0, 24'sd0);
        load(8'd2, EL_OXYGEN, 8'd6, 24'sd0, 24'sd4096, 24'sd0);
        load(8'd3, EL_HYDROGEN, 8'd5, 24'sd8192, 24'sd0, 24'sd0);
        load(8'd4, EL_OXYGEN, 8'd9, 24'sd12288, 24'sd0, 24'sd0);
        run_search();
        for (int s = 0; s < 5; s++) read_atom(8'(s), 4'(s));
        read_atom(8'd4, 4'd15);
        run_search();
        configure(5, 8'd7, 16'd0, 4'd2);
        run_search();
        read_atom(8'd0, 4'd1);
        configure(5, 8'd7, 16'hffff, 4'd15);
        run_search();
        read_atom(8'd1, 4'd3);
        configure(5, 8'd7, 16'd9830, 4'd0);
        run_search();
        configure(0, 8'd255, 16'd9830, 4'd2);
        run_search();
        read_atom(8'd255, 4'd0);

        // pause until every result is back before going random
        drain();

        while (n_load + n_run + n_read < ITEM_GOAL) begin
            n_phase++;
            quiet = ($urandom_range(0, 5) == 0);
            pick = $urandom_range(0, 19);
            rf = 8'($urandom);
            if (pick == 0 && big_left > 0) begin
                // whole table: over-range count counts as all slots
                big_left--;
                configure(big_left == 0 ? 511 : 256, rf, 16'($urandom_range(0, 20000)), 4'd1);
                run_search();
                repeat (4) read_atom(8'($urandom), 4'($urandom));
                continue;
            end
            n = (pick == 1) ? 0 : $urandom_range(1, 12);
            case ($urandom_range(0, 5))
                0: configure(n, rf, 16'd0, 4'($urandom));
                1: configure(n, rf, 16'hffff, 4'($urandom));
                default: configure(n, rf, 16'($urandom_range(6000, 20000)),
                                   ($urandom_range(0, 3) == 0) ? 4'd15 : 4'($urandom_range(0, 4)));
            endcase
            bx = 24'($urandom);
            by = 24'($urandom);
            bz = 24'($urandom);
            for (int i = 0; i < n; i++) begin
                pick = $urandom_range(0, 9);
                el = (pick < 4) ? EL_HYDROGEN : (pick < 8) ? EL_OXYGEN : EL_OTHER;
                load(8'(i), el, rf + 8'($urandom_range(0, 3)), near(bx), near(by), near(bz));
            end
            repeat ($urandom_range(1, 2)) begin
                run_search();
                repeat ($urandom_range(3, 8))
                    read_atom(8'($urandom_range(0, n + 2)), 4'($urandom));
            end
            // noise: stray loads and reads anywhere
            repeat ($urandom_range(0, 3)) begin
                if ($urandom_range(0, 1))
                    load(8'($urandom), 2'($urandom_range(0, 2)), 8'($urandom),
                         24'($urandom), 24'($urandom), 24'($urandom));
                else
                    read_atom(8'($urandom), 4'($urandom));
            end
            if ($urandom_range(0, 2) == 0) run_search();
        end

        s_valid <= 0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("%0d phases: %0d loads, %0d searches, %0d reads, %0d results checked",
                 n_phase, n_load, n_run, n_read, n_results);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
hdl/phs_pkg.sv
hdl/phs_tables.sv
hdl/phs_dist.sv
hdl/proton_hop_state_search.sv
sim/testbench.sv
